>>> sv/sgr_pkg.sv
// sgr_pkg: shared types, constants and helper functions for the seven-segment
// glyph rectangle generator
// no dependencies
`timescale 1ns / 1ps

package sgr_pkg;

	localparam int NUM_SLOTS = 7;
	localparam int SLOT_W = $clog2(NUM_SLOTS);

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam logic [3:0] PIECE_UPPER_DOT = 4'd7;
	localparam logic [3:0] PIECE_LOWER_DOT = 4'd8;

	localparam logic [15:0] MAX_COORD = 16'd4095;

	// register defaults
	localparam logic [7:0] RST_DIGIT_WIDTH = 8'd16;
	localparam logic [7:0] RST_DIGIT_HEIGHT = 8'd32;
	localparam logic [5:0] RST_STROKE = 6'd3;
	localparam logic [7:0] RST_COLON_WIDTH = 8'd6;
	localparam logic [7:0] RST_SPACING = 8'd2;
	localparam logic [15:0] RST_ON_COLOR = 16'd1;
	localparam logic [12:0] RST_DISP_WIDTH = 13'd168;
	localparam logic [12:0] RST_DISP_HEIGHT = 13'd384;

	typedef enum logic [2:0] {
		REG_DIGIT_WIDTH = 3'd0,
		REG_DIGIT_HEIGHT = 3'd1,
		REG_STROKE = 3'd2,
		REG_COLON_WIDTH = 3'd3,
		REG_SPACING = 3'd4,
		REG_ON_COLOR = 3'd5,
		REG_DISP_WIDTH = 3'd6,
		REG_DISP_HEIGHT = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_DIGIT = 2'd1,
		KIND_COLON = 2'd2
	} glyph_kind_t;

	typedef struct packed {
		logic [7:0] digit_width;
		logic [7:0] digit_height;
		logic [5:0] stroke_thickness;
		logic [7:0] colon_width;
		logic [7:0] glyph_spacing;
		logic [15:0] on_color;
		logic [12:0] display_width;
		logic [12:0] display_height;
	} cfg_t;

	typedef struct packed {
		logic [7:0] glyph_code;
		logic text_start;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
	} glyph_t;

	typedef struct packed {
		logic rect_valid;
		logic [11:0] x_left;
		logic [11:0] y_top;
		logic [11:0] x_right;
		logic [11:0] y_bottom;
		logic [15:0] fill_color;
		logic [3:0] piece_id;
		logic signed [15:0] text_width;
		logic last_of_item;
	} result_t;

	typedef struct packed {
		glyph_kind_t kind;
		logic [15:0] x;
		logic [15:0] y;
		logic [NUM_SLOTS-1:0] present;
		logic [15:0] width;
	} pen_stage_t;

	typedef struct packed {
		logic [15:0] x1;
		logic [15:0] y1;
		logic [15:0] x2;
		logic [15:0] y2;
	} corner_t;

	typedef struct packed {
		logic colon;
		logic [NUM_SLOTS-1:0] present;
		corner_t [NUM_SLOTS-1:0] rect;
		logic [15:0] width;
	} geom_stage_t;

	typedef struct packed {
		logic keep;
		logic [11:0] x1;
		logic [11:0] y1;
		logic [11:0] x2;
		logic [11:0] y2;
	} clip_t;

	// segments a..g in bits 0..6
	function automatic logic [NUM_SLOTS-1:0] seg_mask(input logic [3:0] digit);
		logic [NUM_SLOTS-1:0] m;
		case (digit)
			4'd0: m = 7'h3F;
			4'd1: m = 7'h06;
			4'd2: m = 7'h5B;
			4'd3: m = 7'h4F;
			4'd4: m = 7'h66;
			4'd5: m = 7'h6D;
			4'd6: m = 7'h7D;
			4'd7: m = 7'h07;
			4'd8: m = 7'h7F;
			4'd9: m = 7'h6F;
			default: m = '0;
		endcase
		return m;
	endfunction

	// exact for v below 512, by reciprocal 171/512
	function automatic logic [7:0] div3(input logic [8:0] v);
		logic [17:0] p;
		p = {9'd0, v} * 18'd171;
		return p[16:9];
	endfunction

	// order corners, drop if off screen, clamp to the display
	function automatic clip_t clip_rect(input corner_t c, input logic [12:0] dw,
			input logic [12:0] dh);
		logic signed [15:0] x1, y1, x2, y2, mx, my;
		logic drop;
		clip_t r;
		x1 = ($signed(c.x1) > $signed(c.x2)) ? c.x2 : c.x1;
		x2 = ($signed(c.x1) > $signed(c.x2)) ? c.x1 : c.x2;
		y1 = ($signed(c.y1) > $signed(c.y2)) ? c.y2 : c.y1;
		y2 = ($signed(c.y1) > $signed(c.y2)) ? c.y1 : c.y2;
		mx = dw[12] ? MAX_COORD : ({3'b000, dw} - 16'd1);
		my = dh[12] ? MAX_COORD : ({3'b000, dh} - 16'd1);
		drop = (mx < 16'sd0) || (my < 16'sd0) || (x2 < 16'sd0) || (y2 < 16'sd0)
			|| (x1 > mx) || (y1 > my);
		r.keep = !drop;
		r.x1 = (x1 < 16'sd0) ? 12'd0 : x1[11:0];
		r.y1 = (y1 < 16'sd0) ? 12'd0 : y1[11:0];
		r.x2 = (x2 > mx) ? mx[11:0] : x2[11:0];
		r.y2 = (y2 > my) ? my[11:0] : y2[11:0];
		return r;
	endfunction

endpackage

>>> sv/seven_segment_glyph_rect_generator_unit.sv
// seven_segment_glyph_rect_generator_unit: top level with configuration registers
// depends on sgr_pkg, sgr_pen, sgr_geom, sgr_emit
//
// usage: one character per request on the glyph channel (glyph_valid/glyph_stall);
// text_start with origin_x/origin_y begins a new text at that origin. digits give
// one rectangle per visible lit segment (order a..g), a colon one per visible dot,
// and nothing visible gives one empty result. results leave on the piece channel
// (piece_valid/piece_stall), last_of_item marks the final one of each request.
// path: a request passes the pen stage, corner stage, clip bank and output
// register in that order before its first result is presented.
// throughput: a request holds the clip bank until its last result has left, with
// up to seven rectangles, since the bank hands out one result per cycle while the
// output is not stalled; the stages in front can each take one request meanwhile,
// so characters that draw nothing pass at one per cycle when not stalled.
// a stalled result holds in the output register; stalls propagate back stage by
// stage to glyph_stall.
// reset clears the pen to zero, marks the next glyph as first, empties all
// stages and loads the register defaults. configuration writes (cfg_wr_en,
// cfg_index, cfg_data) take effect at once and belong to idle periods.
`timescale 1ns / 1ps

module seven_segment_glyph_rect_generator_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic             glyph_valid,
	output logic             glyph_stall,
	input  sgr_pkg::glyph_t  glyph,
	output logic             piece_valid,
	input  logic             piece_stall,
	output sgr_pkg::result_t piece
);
	import sgr_pkg::*;

	cfg_t cfg_q;

	logic geom_ready, valid_s1, bank_free, valid_s2;
	pen_stage_t stage_s1;
	geom_stage_t stage_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.digit_width <= RST_DIGIT_WIDTH;
			cfg_q.digit_height <= RST_DIGIT_HEIGHT;
			cfg_q.stroke_thickness <= RST_STROKE;
			cfg_q.colon_width <= RST_COLON_WIDTH;
			cfg_q.glyph_spacing <= RST_SPACING;
			cfg_q.on_color <= RST_ON_COLOR;
			cfg_q.display_width <= RST_DISP_WIDTH;
			cfg_q.display_height <= RST_DISP_HEIGHT;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_DIGIT_WIDTH: cfg_q.digit_width <= cfg_data[7:0];
				REG_DIGIT_HEIGHT: cfg_q.digit_height <= cfg_data[7:0];
				REG_STROKE: cfg_q.stroke_thickness <= cfg_data[5:0];
				REG_COLON_WIDTH: cfg_q.colon_width <= cfg_data[7:0];
				REG_SPACING: cfg_q.glyph_spacing <= cfg_data[7:0];
				REG_ON_COLOR: cfg_q.on_color <= cfg_data;
				REG_DISP_WIDTH: cfg_q.display_width <= cfg_data[12:0];
				REG_DISP_HEIGHT: cfg_q.display_height <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	sgr_pen u_pen (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.glyph_valid (glyph_valid),
		.glyph_stall (glyph_stall),
		.glyph       (glyph),
		.geom_ready  (geom_ready),
		.valid_s1    (valid_s1),
		.stage_s1    (stage_s1)
	);

	sgr_geom u_geom (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.valid_s1   (valid_s1),
		.stage_s1   (stage_s1),
		.geom_ready (geom_ready),
		.bank_free  (bank_free),
		.valid_s2   (valid_s2),
		.stage_s2   (stage_s2)
	);

	sgr_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.valid_s2    (valid_s2),
		.stage_s2    (stage_s2),
		.bank_free   (bank_free),
		.piece_valid (piece_valid),
		.piece_stall (piece_stall),
		.piece       (piece)
	);

endmodule

>>> sv/sgr_pen.sv
// sgr_pen: input register stage, pen position and first-glyph tracking
// depends on sgr_pkg
`timescale 1ns / 1ps

module sgr_pen (
	input  logic                clk,
	input  logic                arst_n,
	input  sgr_pkg::cfg_t       cfg,
	input  logic                glyph_valid,
	output logic                glyph_stall,
	input  sgr_pkg::glyph_t     glyph,
	input  logic                geom_ready,
	output logic                valid_s1,
	output sgr_pkg::pen_stage_t stage_s1
);
	import sgr_pkg::*;

	logic [15:0] pen_x_q, org_x_q, top_y_q;
	logic first_q;

	logic accept, s1_open;
	logic [15:0] px, ox, ty, px_draw, pen_next;
	logic first_cur, draw;
	logic [7:0] gw;
	glyph_kind_t kind;
	pen_stage_t stage_d;

	assign s1_open = !valid_s1 || geom_ready;
	assign glyph_stall = !s1_open;
	assign accept = glyph_valid && s1_open;

	always_comb begin
		px = glyph.text_start ? glyph.origin_x : pen_x_q;
		ox = glyph.text_start ? glyph.origin_x : org_x_q;
		ty = glyph.text_start ? glyph.origin_y : top_y_q;
		first_cur = glyph.text_start ? 1'b1 : first_q;
		if (glyph.glyph_code == CH_COLON) begin
			kind = KIND_COLON;
			gw = cfg.colon_width;
		end else if (glyph.glyph_code >= CH_ZERO && glyph.glyph_code <= CH_NINE) begin
			kind = KIND_DIGIT;
			gw = cfg.digit_width;
		end else begin
			kind = KIND_NONE;
			gw = 8'd0;
		end
		draw = (gw != 8'd0);
		px_draw = first_cur ? px : (px + {8'd0, cfg.glyph_spacing});
		pen_next = draw ? (px_draw + {8'd0, gw}) : px;
		stage_d.kind = draw ? kind : KIND_NONE;
		stage_d.x = px_draw;
		stage_d.y = ty;
		case (stage_d.kind)
			KIND_DIGIT: stage_d.present = seg_mask(4'(glyph.glyph_code - CH_ZERO));
			KIND_COLON: stage_d.present = 7'b0000011;
			default: stage_d.present = '0;
		endcase
		stage_d.width = pen_next - ox;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			org_x_q <= '0;
			top_y_q <= '0;
			first_q <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				pen_x_q <= pen_next;
				org_x_q <= ox;
				top_y_q <= ty;
				first_q <= first_cur && !draw;
				valid_s1 <= 1'b1;
			end else if (geom_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1 <= stage_d;
		end
	end

endmodule

>>> sv/sgr_geom.sv
// sgr_geom: corner coordinates of all segment and dot rectangles of a glyph
// depends on sgr_pkg
`timescale 1ns / 1ps

module sgr_geom (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sgr_pkg::cfg_t        cfg,
	input  logic                 valid_s1,
	input  sgr_pkg::pen_stage_t  stage_s1,
	output logic                 geom_ready,
	input  logic                 bank_free,
	output logic                 valid_s2,
	output sgr_pkg::geom_stage_t stage_s2
);
	import sgr_pkg::*;

	logic load;
	logic [15:0] x, y, w, h, t, th;
	logic [15:0] midy, gtop, gbot, topy2, boty1, boty2, lx2, rx1, rx2;
	logic [15:0] hx1, hx2, upy1, upy2, loy2;
	logic signed [9:0] dv, hv;
	logic [15:0] cx, cx2, cty, cby, cty2, cby2;
	geom_stage_t stage_d;

	assign geom_ready = !valid_s2 || bank_free;
	assign load = valid_s1 && geom_ready;

	always_comb begin
		x = stage_s1.x;
		y = stage_s1.y;
		w = {8'd0, cfg.digit_width};
		h = {8'd0, cfg.digit_height};
		t = {10'd0, cfg.stroke_thickness};
		th = {11'd0, cfg.stroke_thickness[5:1]};
		// digit
		midy = y + {9'd0, cfg.digit_height[7:1]};
		gtop = midy - th;
		gbot = gtop + t - 16'd1;
		topy2 = y + t - 16'd1;
		boty1 = y + h - t;
		boty2 = y + h - 16'd1;
		lx2 = x + t - 16'd1;
		rx1 = x + w - t;
		rx2 = x + w - 16'd1;
		hx1 = x + t;
		hx2 = x + w - t - 16'd1;
		upy1 = y + t;
		upy2 = midy - 16'd1;
		loy2 = y + h - t - 16'd1;
		// colon, offset halved toward zero
		dv = $signed({2'b00, cfg.colon_width}) - $signed({4'b0000, cfg.stroke_thickness});
		hv = (dv + $signed({9'd0, dv[9]})) >>> 1;
		cx = x + {{6{hv[9]}}, hv};
		cx2 = cx + t - 16'd1;
		cty = y + {8'd0, div3({1'b0, cfg.digit_height})} - th;
		cby = y + {8'd0, div3({cfg.digit_height, 1'b0})} - th;
		cty2 = cty + t - 16'd1;
		cby2 = cby + t - 16'd1;

		stage_d.colon = (stage_s1.kind == KIND_COLON);
		stage_d.present = stage_s1.present;
		stage_d.width = stage_s1.width;
		stage_d.rect[0] = '{x1: hx1, y1: y, x2: hx2, y2: topy2};
		stage_d.rect[1] = '{x1: rx1, y1: upy1, x2: rx2, y2: upy2};
		stage_d.rect[2] = '{x1: rx1, y1: midy, x2: rx2, y2: loy2};
		stage_d.rect[3] = '{x1: hx1, y1: boty1, x2: hx2, y2: boty2};
		stage_d.rect[4] = '{x1: x, y1: midy, x2: lx2, y2: loy2};
		stage_d.rect[5] = '{x1: x, y1: upy1, x2: lx2, y2: upy2};
		stage_d.rect[6] = '{x1: hx1, y1: gtop, x2: hx2, y2: gbot};
		if (stage_d.colon) begin
			stage_d.rect[0] = '{x1: cx, y1: cty, x2: cx2, y2: cty2};
			stage_d.rect[1] = '{x1: cx, y1: cby, x2: cx2, y2: cby2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			if (load) begin
				valid_s2 <= 1'b1;
			end else if (bank_free) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			stage_s2 <= stage_d;
		end
	end

endmodule

>>> sv/sgr_emit.sv
// sgr_emit: clipping into a rectangle bank and one-per-cycle result
// output while not stalled; depends on sgr_pkg
`timescale 1ns / 1ps

module sgr_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sgr_pkg::cfg_t        cfg,
	input  logic                 valid_s2,
	input  sgr_pkg::geom_stage_t stage_s2,
	output logic                 bank_free,
	output logic                 piece_valid,
	input  logic                 piece_stall,
	output sgr_pkg::result_t     piece
);
	import sgr_pkg::*;

	logic bank_valid_s3, colon_s3;
	logic [NUM_SLOTS-1:0] rem_s3;
	clip_t [NUM_SLOTS-1:0] clip_s3;
	logic [15:0] width_s3;

	logic out_ready, emit, load, last;
	logic [SLOT_W-1:0] sel;
	logic [NUM_SLOTS-1:0] rem_clr, keep;
	clip_t [NUM_SLOTS-1:0] clip_d;
	result_t res_d;

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			clip_d[i] = clip_rect(stage_s2.rect[i], cfg.display_width, cfg.display_height);
			keep[i] = stage_s2.present[i] && clip_d[i].keep;
		end
	end

	always_comb begin
		sel = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (rem_s3[i]) begin
				sel = SLOT_W'(i);
			end
		end
		rem_clr = rem_s3 & ~(NUM_SLOTS'(1) << sel);
		last = (rem_clr == '0);
		out_ready = !piece_valid || !piece_stall;
		emit = bank_valid_s3 && out_ready;
		bank_free = !bank_valid_s3 || (out_ready && last);
		load = valid_s2 && bank_free;

		res_d = '0;
		res_d.text_width = width_s3;
		res_d.last_of_item = last;
		if (rem_s3 != '0) begin
			res_d.rect_valid = 1'b1;
			res_d.x_left = clip_s3[sel].x1;
			res_d.y_top = clip_s3[sel].y1;
			res_d.x_right = clip_s3[sel].x2;
			res_d.y_bottom = clip_s3[sel].y2;
			res_d.fill_color = cfg.on_color;
			if (colon_s3) begin
				res_d.piece_id = (sel == '0) ? PIECE_UPPER_DOT : PIECE_LOWER_DOT;
			end else begin
				res_d.piece_id = 4'(sel);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_valid_s3 <= 1'b0;
			rem_s3 <= '0;
			piece_valid <= 1'b0;
		end else begin
			if (load) begin
				bank_valid_s3 <= 1'b1;
				rem_s3 <= keep;
			end else if (emit) begin
				bank_valid_s3 <= !last;
				rem_s3 <= rem_clr;
			end
			if (emit) begin
				piece_valid <= 1'b1;
			end else if (out_ready) begin
				piece_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			clip_s3 <= clip_d;
			colon_s3 <= stage_s2.colon;
			width_s3 <= stage_s2.width;
		end
		if (emit) begin
			piece <= res_d;
		end
	end

	// an empty result always closes its request
	assert property (@(posedge clk) disable iff (!arst_n)
		piece_valid && !piece.rect_valid |-> piece.last_of_item)
		else $error("empty result not marked last");

	// clipped corners stay ordered
	assert property (@(posedge clk) disable iff (!arst_n)
		piece_valid && piece.rect_valid |->
		(piece.x_left <= piece.x_right) && (piece.y_top <= piece.y_bottom))
		else $error("clipped rectangle corners out of order");

	// bank holds its pending set while the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		bank_valid_s3 && !out_ready |=> bank_valid_s3 && $stable(rem_s3))
		else $error("bank changed while output blocked");

	// piece numbers stay within segments and dots
	assert property (@(posedge clk) disable iff (!arst_n)
		piece_valid && piece.rect_valid |-> piece.piece_id <= PIECE_LOWER_DOT)
		else $error("piece number out of range");

endmodule
